// ===== rtl/lom_pkg.sv =====
`default_nettype none

package lom_pkg;

	localparam int PRICE_W  = 31;
	localparam int AMT_W    = 31;
	localparam int VALUE_W  = 62;
	localparam int OUTSLOT_W = 5;

	// a run ends after this many fills at most, then the done response
	localparam int FILL_CNT_W = 5;
	localparam logic [FILL_CNT_W-1:0] MAX_FILLS = 5'd31;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_MATCH = 2'd2;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct packed {
		logic [1:0]         op;
		logic               side;
		logic [PRICE_W-1:0] limit_price;
		logic [AMT_W-1:0]   order_amount;
		logic [AMT_W-1:0]   already_filled;
	} req_t;

	typedef struct packed {
		logic                 is_trade;
		logic [OUTSLOT_W-1:0] buy_slot;
		logic [OUTSLOT_W-1:0] sell_slot;
		logic [AMT_W-1:0]     fill_amount;
		logic [PRICE_W-1:0]   fill_price;
		logic [VALUE_W-1:0]   seller_credit;
		logic [VALUE_W-1:0]   buyer_refund;
		logic                 buy_done;
		logic                 sell_done;
		logic                 last;
	} rsp_t;

	// one book slot
	typedef struct packed {
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [AMT_W-1:0]   amount;
		logic [AMT_W-1:0]   filled;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/lom_ram.sv =====
`default_nettype none

module lom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/limit_order_matcher.sv =====
// limit order matcher: order book of one asset with price priority matching
//
// request channel (req_valid / req_stall / req): clear the book, load one
// order into the next free slot, or run a match. back-to-back loads go in at one
// per cycle. loads into a full book are dropped. req_stall is high for the
// whole match run.
//
// response channel (rsp_valid / rsp_stall / rsp): a match run gives zero or
// more fill responses and then one done response with last set. each fill
// takes one pass over the book through the single read port of the order
// memory, which picks best buy and best sell at once, then an evaluate
// state, two steps on the one shared multiplier (seller credit, then buyer
// refund) that also write the updated filled amounts back through the
// memory write port, and a hand-off state. the closing pass ends in the done
// response. the response register holds while rsp_stall is high; the
// sequencer waits in its hand-off state until the register frees up.
//
// reset empties the book (the order memory itself is not cleared, only slots
// below the count are ever read) and drops any pending response.
`default_nettype none

module limit_order_matcher #(
	parameter int ORDER_SLOTS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire lom_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output lom_pkg::rsp_t      rsp
);

	localparam int SLOT_W = $clog2(ORDER_SLOTS);
	localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(ORDER_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_MUL1,
		ST_MUL2,
		ST_EMIT,
		ST_LAST
	} state_t;

	state_t state_q;

	// book fill level and scan control
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               scan_idx_q;
	logic                           rd_vld_s1;
	logic [SLOT_W-1:0]              rd_slot_s1;
	logic [lom_pkg::FILL_CNT_W-1:0] fill_cnt_q;

	// best buy / best sell found by the current pass
	logic                        bb_vld_q, bs_vld_q;
	logic [SLOT_W-1:0]           bb_slot_q, bs_slot_q;
	logic [lom_pkg::PRICE_W-1:0] bb_price_q, bs_price_q;
	logic [lom_pkg::AMT_W-1:0]   bb_amt_q, bs_amt_q;
	logic [lom_pkg::AMT_W-1:0]   bb_filled_q, bs_filled_q;
	logic [lom_pkg::AMT_W-1:0]   bb_left_q, bs_left_q;

	// fill in progress
	logic [lom_pkg::AMT_W-1:0]   qty_q;
	logic [lom_pkg::PRICE_W-1:0] diff_q;
	logic [lom_pkg::VALUE_W-1:0] credit_q;
	logic [lom_pkg::VALUE_W-1:0] refund_q;
	logic                        buy_done_q, sell_done_q;

	// memory ports
	logic                   ram_we;
	logic [SLOT_W-1:0]      ram_waddr;
	lom_pkg::entry_t        ram_wdata;
	logic [SLOT_W-1:0]      ram_raddr;
	logic [$bits(lom_pkg::entry_t)-1:0] ram_rdata;
	lom_pkg::entry_t        rd_entry;

	logic                        accept;
	logic                        out_free;
	logic                        issue;
	logic                        emit_trade, emit_last;
	logic                        go_fill;
	logic                        rd_live;
	logic [lom_pkg::AMT_W-1:0]   rd_left;
	logic                        take_buy, take_sell;
	logic [lom_pkg::PRICE_W-1:0] mul_b;
	logic [lom_pkg::VALUE_W-1:0] product;

	assign req_stall  = (state_q != ST_IDLE);
	assign accept     = req_valid && !req_stall;
	assign out_free   = !rsp_valid || !rsp_stall;
	assign issue      = (state_q == ST_SCAN) && (scan_idx_q < count_q);
	assign emit_trade = (state_q == ST_EMIT) && out_free;
	assign emit_last  = (state_q == ST_LAST) && out_free;

	// a fill goes ahead only if both sides have a live order, prices cross
	// and the run has not hit its fill limit
	assign go_fill = bb_vld_q && bs_vld_q && (bb_price_q >= bs_price_q)
		&& (fill_cnt_q != lom_pkg::MAX_FILLS);

	// candidate from the read port, one slot per cycle
	assign rd_entry = lom_pkg::entry_t'(ram_rdata);
	assign rd_live  = rd_entry.amount > rd_entry.filled;
	assign rd_left  = rd_entry.amount - rd_entry.filled;
	assign take_buy = rd_vld_s1 && rd_live && (rd_entry.side == lom_pkg::SIDE_BUY)
		&& (!bb_vld_q || (rd_entry.price > bb_price_q));
	assign take_sell = rd_vld_s1 && rd_live && (rd_entry.side == lom_pkg::SIDE_SELL)
		&& (!bs_vld_q || (rd_entry.price < bs_price_q));

	// shared multiplier: credit first, refund second
	assign mul_b   = (state_q == ST_MUL1) ? bs_price_q : diff_q;
	assign product = lom_pkg::VALUE_W'(qty_q) * lom_pkg::VALUE_W'(mul_b);

	// write port: loads when idle, filled-amount updates during the multiplies
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[SLOT_W-1:0];
		ram_wdata = '{side: req.side, price: req.limit_price,
			amount: req.order_amount, filled: req.already_filled};
		case (state_q)
			ST_IDLE: begin
				ram_we = accept && (req.op == lom_pkg::OP_LOAD) && (count_q < SLOTS_C);
			end
			ST_MUL1: begin
				ram_we    = 1'b1;
				ram_waddr = bb_slot_q;
				ram_wdata = '{side: lom_pkg::SIDE_BUY, price: bb_price_q,
					amount: bb_amt_q, filled: bb_filled_q + qty_q};
			end
			ST_MUL2: begin
				ram_we    = 1'b1;
				ram_waddr = bs_slot_q;
				ram_wdata = '{side: lom_pkg::SIDE_SELL, price: bs_price_q,
					amount: bs_amt_q, filled: bs_filled_q + qty_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_raddr = scan_idx_q[SLOT_W-1:0];

	lom_ram #(
		.WIDTH($bits(lom_pkg::entry_t)),
		.DEPTH(ORDER_SLOTS)
	) u_book (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, control state and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			fill_cnt_q <= '0;
			bb_vld_q   <= 1'b0;
			bs_vld_q   <= 1'b0;
			rsp_valid  <= 1'b0;
			rsp        <= '0;
		end else begin
			// response register loads when free, else drains on acceptance
			if (emit_trade || emit_last) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			if (emit_trade) begin
				rsp <= '{is_trade: 1'b1,
					buy_slot: lom_pkg::OUTSLOT_W'(bb_slot_q),
					sell_slot: lom_pkg::OUTSLOT_W'(bs_slot_q),
					fill_amount: qty_q, fill_price: bs_price_q,
					seller_credit: credit_q, buyer_refund: refund_q,
					buy_done: buy_done_q, sell_done: sell_done_q, last: 1'b0};
			end else if (emit_last) begin
				// done response: everything zero except last
				rsp <= '{is_trade: 1'b0, buy_slot: '0, sell_slot: '0,
					fill_amount: '0, fill_price: '0, seller_credit: '0,
					buyer_refund: '0, buy_done: 1'b0, sell_done: 1'b0, last: 1'b1};
			end
			rd_vld_s1 <= issue;
			if (take_buy) begin
				bb_vld_q <= 1'b1;
			end
			if (take_sell) begin
				bs_vld_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.op)
							lom_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							lom_pkg::OP_LOAD: begin
								if (count_q < SLOTS_C) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							lom_pkg::OP_MATCH: begin
								fill_cnt_q <= '0;
								scan_idx_q <= '0;
								bb_vld_q   <= 1'b0;
								bs_vld_q   <= 1'b0;
								state_q    <= ST_SCAN;
							end
							default: begin
								count_q <= count_q;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= go_fill ? ST_MUL1 : ST_LAST;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						fill_cnt_q <= fill_cnt_q + lom_pkg::FILL_CNT_W'(1);
						scan_idx_q <= '0;
						bb_vld_q   <= 1'b0;
						bs_vld_q   <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_LAST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		rd_slot_s1 <= scan_idx_q[SLOT_W-1:0];
		if (take_buy) begin
			bb_slot_q   <= rd_slot_s1;
			bb_price_q  <= rd_entry.price;
			bb_amt_q    <= rd_entry.amount;
			bb_filled_q <= rd_entry.filled;
			bb_left_q   <= rd_left;
		end
		if (take_sell) begin
			bs_slot_q   <= rd_slot_s1;
			bs_price_q  <= rd_entry.price;
			bs_amt_q    <= rd_entry.amount;
			bs_filled_q <= rd_entry.filled;
			bs_left_q   <= rd_left;
		end
		if (state_q == ST_EVAL) begin
			// smaller remaining amount trades; the side it came from is now done
			qty_q       <= (bb_left_q < bs_left_q) ? bb_left_q : bs_left_q;
			diff_q      <= bb_price_q - bs_price_q;
			buy_done_q  <= (bb_left_q <= bs_left_q);
			sell_done_q <= (bs_left_q <= bb_left_q);
		end
		if (state_q == ST_MUL1) begin
			credit_q <= product;
		end
		if (state_q == ST_MUL2) begin
			refund_q <= product;
		end
	end

endmodule

`default_nettype wire
